// ----- rtl/unicode_quick_check_range_lookup_unit_defines.svh -----
// Assertion macros shared by the quick-check lookup RTL.
// Each macro expects clk and arst_n in the scope of the module that uses it.
`ifndef UNICODE_QUICK_CHECK_RANGE_LOOKUP_UNIT_DEFINES_SVH
`define UNICODE_QUICK_CHECK_RANGE_LOOKUP_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UQC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UQC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/uqc_pkg.sv -----
// Shared types, constants and helper functions for the quick-check lookup unit.
// No dependencies; every RTL module and interface imports this package.
`timescale 1ns / 1ps

package uqc_pkg;

	localparam int ENTRIES_PER_FORM = 1024;
	localparam int SCAN_WINDOW      = 8;
	localparam int FORMS            = 4;

	localparam int IDX_W      = $clog2(ENTRIES_PER_FORM);
	localparam int NUM_W      = IDX_W + 1;
	localparam int FORM_SEL_W = $clog2(FORMS);
	localparam int ADDR_W     = FORM_SEL_W + IDX_W;
	localparam int DEPTH      = FORMS * ENTRIES_PER_FORM;

	localparam int CP_W        = 21;
	localparam int RUN_W       = 24;
	localparam int CHECK_W     = 8;
	localparam int COUNT_W     = 11;
	localparam int FORM_W      = 3;
	localparam int ENTRY_IDX_W = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int SUM_W       = RUN_W + 1;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [FORM_SEL_W-1:0] FORM_COMPOSED          = FORM_SEL_W'(0);
	localparam logic [FORM_SEL_W-1:0] FORM_DECOMPOSED        = FORM_SEL_W'(1);
	localparam logic [FORM_SEL_W-1:0] FORM_COMPAT_COMPOSED   = FORM_SEL_W'(2);
	localparam logic [FORM_SEL_W-1:0] FORM_COMPAT_DECOMPOSED = FORM_SEL_W'(3);

	typedef enum logic [1:0] {
		OUT_TABLE   = 2'd0,
		OUT_YES     = 2'd1,
		OUT_INVALID = 2'd2,
		OUT_LOADED  = 2'd3
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNT_COMPOSED          = 3'd0,
		REG_COUNT_DECOMPOSED        = 3'd1,
		REG_COUNT_COMPAT_COMPOSED   = 3'd2,
		REG_COUNT_COMPAT_DECOMPOSED = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CP_W-1:0]    start;
		logic [CP_W-1:0]    last;
		logic [RUN_W-1:0]   run;
		logic [CHECK_W-1:0] check;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic covers(entry_t e, logic [CP_W-1:0] cp);
		return (cp >= e.start) && (cp <= e.last);
	endfunction

	function automatic logic within_run(entry_t e, logic [CP_W-1:0] cp);
		logic [SUM_W-1:0] lim;
		lim = SUM_W'(e.start) + SUM_W'(e.run);
		return SUM_W'(cp) <= lim;
	endfunction

endpackage

// ----- rtl/uqc_if.sv -----
// Valid/ready channel interfaces for lookup requests and results.
// Depends on uqc_pkg for field widths.
`timescale 1ns / 1ps

interface uqc_req_if import uqc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [FORM_W-1:0]      form;
	logic [ENTRY_IDX_W-1:0] entry_index;
	logic [CP_W-1:0]        codepoint;
	logic [CP_W-1:0]        range_last;
	logic [RUN_W-1:0]       run_length;
	logic [CHECK_W-1:0]     check_byte;

	modport source (
		output valid, opcode, form, entry_index, codepoint, range_last, run_length,
			check_byte,
		input  ready
	);
	modport sink (
		input  valid, opcode, form, entry_index, codepoint, range_last, run_length,
			check_byte,
		output ready
	);
endinterface

interface uqc_rsp_if import uqc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         outcome;
	logic [CHECK_W-1:0] check_value;

	modport source (
		output valid, outcome, check_value,
		input  ready
	);
	modport sink (
		input  valid, outcome, check_value,
		output ready
	);
endinterface

// ----- rtl/uqc_table_mem.sv -----
// Range table storage: all four forms in one synchronous single-port-read RAM.
// Depends on uqc_pkg for entry_t and mem_req_t.
`timescale 1ns / 1ps

module uqc_table_mem import uqc_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_data <= mem[req.raddr];
	end

endmodule

// ----- rtl/uqc_count_regs.sv -----
// Per-form entry count registers with write decode and saturation on read.
// Depends on uqc_pkg for widths and register indexes.
`timescale 1ns / 1ps

module uqc_count_regs import uqc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COUNT_W-1:0]    cfg_wdata,
	input  logic [FORM_SEL_W-1:0] sel_form,
	output logic [NUM_W-1:0]      num
);

	logic [COUNT_W-1:0] counts_q [FORMS];
	logic [COUNT_W-1:0] sel_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FORMS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNT_COMPOSED:          counts_q[FORM_COMPOSED] <= cfg_wdata;
				REG_COUNT_DECOMPOSED:        counts_q[FORM_DECOMPOSED] <= cfg_wdata;
				REG_COUNT_COMPAT_COMPOSED:   counts_q[FORM_COMPAT_COMPOSED] <= cfg_wdata;
				REG_COUNT_COMPAT_DECOMPOSED: counts_q[FORM_COMPAT_DECOMPOSED] <= cfg_wdata;
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// clamp oversized counts to the table size
	always_comb begin
		sel_count = counts_q[sel_form];
		if (32'(sel_count) > ENTRIES_PER_FORM) begin
			num = NUM_W'(ENTRIES_PER_FORM);
		end else begin
			num = NUM_W'(sel_count);
		end
	end

endmodule

// ----- rtl/uqc_search_ctrl.sv -----
// Search sequencer: table loads, bound check, binary search and window scan.
// Depends on uqc_pkg, the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "unicode_quick_check_range_lookup_unit_defines.svh"

module uqc_search_ctrl import uqc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	uqc_req_if.sink          req,
	uqc_rsp_if.source        rsp,
	input  logic [NUM_W-1:0] num,
	output mem_req_t         mem_req,
	input  entry_t           rd_data
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FIRST = 6'b000010,
		ST_LAST  = 6'b000100,
		ST_MID   = 6'b001000,
		ST_SCAN  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [CP_W-1:0]       cp_q;
	logic [FORM_SEL_W-1:0] form_q;
	logic [IDX_W-1:0]      lo_q, hi_q, mid_q, scan_q;
	entry_t                lo_ent_q, hi_ent_q, hit_ent_q;
	logic                  hit_q;
	outcome_t              res_q;

	logic                  rsp_valid_q;
	outcome_t              out_outcome_q;
	logic [CHECK_W-1:0]    out_check_q;

	logic                  in_fire, form_ok, idx_ok, out_free;
	logic [IDX_W-1:0]      first_mid, new_lo, new_hi, new_span, mid_next, scan_next;
	logic [IDX_W-1:0]      rd_idx;
	logic [FORM_SEL_W-1:0] rd_form;
	logic                  cov_lo, cov_hi, cov_mid, go_right, keep_search, scan_empty;
	logic                  scan_last, reject, hit_in_run;

	assign req.ready = (state_q == ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign form_ok   = req.form < FORM_W'(FORMS);
	assign idx_ok    = 32'(req.entry_index) < ENTRIES_PER_FORM;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign first_mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign cov_lo      = covers(lo_ent_q, cp_q);
	assign cov_hi      = covers(hi_ent_q, cp_q);
	assign cov_mid     = covers(rd_data, cp_q);
	assign go_right    = cp_q > rd_data.last;
	assign new_lo      = go_right ? mid_q : lo_q;
	assign new_hi      = go_right ? hi_q : mid_q;
	assign new_span    = new_hi - new_lo;
	assign mid_next    = new_lo + (new_span >> 1);
	assign keep_search = 32'(new_span) > SCAN_WINDOW;
	assign scan_empty  = 32'(new_span) <= 1;
	assign scan_next   = scan_q + IDX_W'(1);
	assign scan_last   = scan_next == hi_q;
	assign reject      = (cp_q < lo_ent_q.start) || (cp_q > rd_data.last);
	assign hit_in_run  = within_run(hit_ent_q, cp_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (!form_ok || req.opcode == OP_LOAD || num == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_FIRST;
					end
				end
			end
			ST_FIRST: state_d = ST_LAST;
			ST_LAST:  state_d = reject ? ST_DONE : ST_MID;
			ST_MID: begin
				if (cov_lo || cov_hi || cov_mid) begin
					state_d = ST_DONE;
				end else if (keep_search) begin
					state_d = ST_MID;
				end else if (scan_empty) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: state_d = (cov_mid || scan_last) ? ST_DONE : ST_SCAN;
			ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	// read address for the entry examined in the next cycle
	always_comb begin
		rd_form = form_q;
		rd_idx  = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd_form = req.form[FORM_SEL_W-1:0];
				rd_idx  = '0;
			end
			ST_FIRST: rd_idx = hi_q;
			ST_LAST:  rd_idx = first_mid;
			ST_MID:   rd_idx = keep_search ? mid_next : new_lo + IDX_W'(1);
			ST_SCAN:  rd_idx = scan_next;
			ST_DONE:  rd_idx = '0;
			default:  rd_idx = '0;
		endcase
	end

	assign mem_req.we          = in_fire && form_ok && req.opcode == OP_LOAD && idx_ok;
	assign mem_req.waddr       = {req.form[FORM_SEL_W-1:0], IDX_W'(req.entry_index)};
	assign mem_req.wdata.start = req.codepoint;
	assign mem_req.wdata.last  = req.range_last;
	assign mem_req.wdata.run   = req.run_length;
	assign mem_req.wdata.check = req.check_byte;
	assign mem_req.raddr       = {rd_form, rd_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cp_q   <= req.codepoint;
					form_q <= req.form[FORM_SEL_W-1:0];
					lo_q   <= '0;
					hi_q   <= IDX_W'(num - NUM_W'(1));
					hit_q  <= 1'b0;
					if (!form_ok) begin
						res_q <= OUT_INVALID;
					end else if (req.opcode == OP_LOAD) begin
						res_q <= OUT_LOADED;
					end else begin
						res_q <= OUT_YES;
					end
				end
			end
			ST_FIRST: lo_ent_q <= rd_data;
			ST_LAST: begin
				hi_ent_q <= rd_data;
				mid_q    <= first_mid;
			end
			ST_MID: begin
				// bounds first, then pivot, as the search order requires
				if (cov_lo) begin
					hit_q     <= 1'b1;
					hit_ent_q <= lo_ent_q;
				end else if (cov_hi) begin
					hit_q     <= 1'b1;
					hit_ent_q <= hi_ent_q;
				end else if (cov_mid) begin
					hit_q     <= 1'b1;
					hit_ent_q <= rd_data;
				end else begin
					lo_q <= new_lo;
					hi_q <= new_hi;
					if (go_right) begin
						lo_ent_q <= rd_data;
					end else begin
						hi_ent_q <= rd_data;
					end
					mid_q  <= mid_next;
					// window ends are already known not to match
					scan_q <= new_lo + IDX_W'(1);
				end
			end
			ST_SCAN: begin
				if (cov_mid) begin
					hit_q     <= 1'b1;
					hit_ent_q <= rd_data;
				end else begin
					scan_q <= scan_next;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					if (hit_q && hit_in_run) begin
						out_outcome_q <= OUT_TABLE;
						out_check_q   <= hit_ent_q.check;
					end else begin
						out_outcome_q <= hit_q ? OUT_YES : res_q;
						out_check_q   <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.outcome     = out_outcome_q;
	assign rsp.check_value = out_check_q;

	`UQC_ASSERT_NEXT(a_accept_starts_work, in_fire, state_q != ST_IDLE, "accepted word left idle")
	`UQC_ASSERT_SAME(a_result_from_done, $rose(rsp_valid_q), $past(state_q) == ST_DONE, "result without finish")
	`UQC_ASSERT_SAME(a_bounds_ordered, (state_q == ST_MID) || (state_q == ST_SCAN), lo_q <= hi_q, "bounds crossed")
	`UQC_ASSERT_SAME(a_scan_inside, state_q == ST_SCAN, (scan_q > lo_q) && (scan_q < hi_q), "scan outside window")

endmodule

// ----- rtl/unicode_quick_check_range_lookup_unit.sv -----
// Normalization quick-check range lookup. Four range tables (one per form) share one
// synchronous RAM with a single read port; every search step is one RAM read. A lookup
// reads the first and last entries, then runs S binary-search steps (at most 7 for 1024
// entries) and scans W entries inside the final window (at most 7) before the result.
// Loads, invalid forms and empty tables skip the search and go straight to the result.
// A finished result waits in an output register while the next word is taken.
`timescale 1ns / 1ps

module unicode_quick_check_range_lookup_unit import uqc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	uqc_req_if.sink              req,
	uqc_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_wdata
);

	logic [NUM_W-1:0] num;
	mem_req_t         mem_req;
	entry_t           rd_data;

	uqc_count_regs u_count_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sel_form  (req.form[FORM_SEL_W-1:0]),
		.num       (num)
	);

	uqc_table_mem u_table_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	uqc_search_ctrl u_search_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.num     (num),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

endmodule

// ----- tb/uqc_lookup_checker.sv -----
// Scoreboard for the quick-check range lookup unit: watches the request, result and
// register-write ports, predicts every result word and compares it with the block's.
// Depends on uqc_pkg and the channel interfaces in uqc_if.sv.
`timescale 1ns / 1ps

module uqc_lookup_checker import uqc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	uqc_req_if                   req,
	uqc_rsp_if                   rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_wdata,
	output int                   fail_count,
	output int                   owed_count
);

	typedef struct packed {
		outcome_t           outcome;
		logic [CHECK_W-1:0] check_value;
	} verdict_t;

	logic [CP_W-1:0]    tab_start [DEPTH];
	logic [CP_W-1:0]    tab_last  [DEPTH];
	logic [RUN_W-1:0]   tab_run   [DEPTH];
	logic [CHECK_W-1:0] tab_check [DEPTH];
	logic [COUNT_W-1:0] form_count [FORMS];
	verdict_t           owed_checks [$];

	function automatic bit holds(input int unsigned slot, input logic [CP_W-1:0] cp);
		return (cp >= tab_start[slot]) && (cp <= tab_last[slot]);
	endfunction

	// Table byte only while the codepoint lies within start plus run length.
	function automatic verdict_t settle(input int unsigned slot, input logic [CP_W-1:0] cp);
		verdict_t v;
		if (32'(cp) <= 32'(tab_start[slot]) + 32'(tab_run[slot])) begin
			v.outcome     = OUT_TABLE;
			v.check_value = tab_check[slot];
		end else begin
			v.outcome     = OUT_YES;
			v.check_value = '0;
		end
		return v;
	endfunction

	function automatic verdict_t search(input logic [FORM_SEL_W-1:0] form_sel,
			input logic [CP_W-1:0] cp);
		int unsigned base, n, lo, hi, mid, i;
		verdict_t v;
		base = int'(form_sel) * ENTRIES_PER_FORM;
		n = form_count[form_sel];
		if (n > ENTRIES_PER_FORM)
			n = ENTRIES_PER_FORM;
		v.outcome     = OUT_YES;
		v.check_value = '0;
		if (n == 0)
			return v;
		lo = 0;
		hi = n - 1;
		if (cp < tab_start[base] || cp > tab_last[base + hi])
			return v;
		// Probe both bounds and the pivot, then pull one bound onto the pivot.
		do begin
			mid = lo + (hi - lo) / 2;
			if (holds(base + lo, cp))
				return settle(base + lo, cp);
			if (holds(base + hi, cp))
				return settle(base + hi, cp);
			if (holds(base + mid, cp))
				return settle(base + mid, cp);
			if (cp > tab_last[base + mid])
				lo = mid;
			else
				hi = mid;
		end while (hi - lo > SCAN_WINDOW);
		for (i = lo; i <= hi; i++) begin
			if (holds(base + i, cp))
				return settle(base + i, cp);
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t              want;
		logic [ADDR_W-1:0]     slot;
		if (!arst_n) begin
			for (int f = 0; f < FORMS; f++)
				form_count[f] = '0;
			owed_checks.delete();
			fail_count = 0;
			owed_count <= 0;
		end else begin
			// Match the result first: a word taken at this edge cannot answer yet.
			if (rsp.valid && rsp.ready) begin
				if (owed_checks.size() == 0) begin
					$error("unexpected result word: outcome %0d check_value %0d",
						rsp.outcome, rsp.check_value);
					fail_count++;
				end else begin
					want = owed_checks.pop_front();
					if (rsp.outcome !== want.outcome) begin
						$error("outcome: expected %0d, got %0d", want.outcome, rsp.outcome);
						fail_count++;
					end
					if (rsp.check_value !== want.check_value) begin
						$error("check_value: expected %0d, got %0d", want.check_value,
							rsp.check_value);
						fail_count++;
					end
				end
			end
			if (cfg_we && cfg_index <= REG_COUNT_COMPAT_DECOMPOSED)
				form_count[cfg_index[FORM_SEL_W-1:0]] = cfg_wdata;
			if (req.valid && req.ready) begin
				if (req.form >= FORMS) begin
					want.outcome     = OUT_INVALID;
					want.check_value = '0;
				end else if (req.opcode == OP_LOAD) begin
					slot = {req.form[FORM_SEL_W-1:0], req.entry_index};
					tab_start[slot] = req.codepoint;
					tab_last[slot]  = req.range_last;
					tab_run[slot]   = req.run_length;
					tab_check[slot] = req.check_byte;
					want.outcome     = OUT_LOADED;
					want.check_value = '0;
				end else begin
					want = search(req.form[FORM_SEL_W-1:0], req.codepoint);
				end
				owed_checks.push_back(want);
			end
			owed_count <= owed_checks.size();
		end
	end

endmodule

// ----- tb/tb_unicode_quick_check_range_lookup_unit.sv -----
// Top of the quick-check lookup testbench: clock, reset, table loads, lookups and count
// programming with random stalls on both channels; uqc_lookup_checker does the scoring.
// Depends on uqc_pkg, uqc_if.sv, the lookup unit and uqc_lookup_checker.
`timescale 1ns / 1ps

module tb_unicode_quick_check_range_lookup_unit;
	import uqc_pkg::*;

	localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
	localparam int RANDOM_WORDS  = 100;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASE_WORDS   = 60;

	typedef struct {
		logic                   opcode;
		logic [FORM_W-1:0]      form;
		logic [ENTRY_IDX_W-1:0] entry_index;
		logic [CP_W-1:0]        codepoint;
		logic [CP_W-1:0]        range_last;
		logic [RUN_W-1:0]       run_length;
		logic [CHECK_W-1:0]     check_byte;
	} req_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COUNT_W-1:0]   cfg_wdata;
	int                   fail_count;
	int                   owed_count;
	bit                   steady;
	int                   words_sent;
	int                   rsp_hold;
	int                   count_plan [FORMS];

	// Copy of what was loaded, used only to aim lookups at interesting codepoints.
	logic [CP_W-1:0]  ent_start [FORMS][ENTRIES_PER_FORM];
	logic [CP_W-1:0]  ent_last  [FORMS][ENTRIES_PER_FORM];
	logic [RUN_W-1:0] ent_run   [FORMS][ENTRIES_PER_FORM];

	uqc_req_if req_ch();
	uqc_rsp_if rsp_ch();

	unicode_quick_check_range_lookup_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	uqc_lookup_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.owed_count (owed_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result-side back-pressure: mostly short stalls, now and then a long one.
	always @(posedge clk) begin
		int r;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold = 0;
		end else if (steady) begin
			rsp_ch.ready <= 1'b1;
		end else if (rsp_hold > 0) begin
			rsp_hold--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				rsp_ch.ready <= 1'b1;
				rsp_hold = $urandom_range(0, 7);
			end else if (r < 90) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold = $urandom_range(0, 2);
			end else if (r < 98) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold = $urandom_range(3, 11);
			end else begin
				rsp_ch.ready <= 1'b0;
				rsp_hold = $urandom_range(19, 59);
			end
		end
	end

	function automatic int idle_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int live_count(input int f);
		return (count_plan[f] > ENTRIES_PER_FORM) ? ENTRIES_PER_FORM : count_plan[f];
	endfunction

	function automatic logic [RUN_W-1:0] pick_run(input int unsigned len);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return RUN_W'($urandom_range(0, len));
		if (r < 6)
			return '0;
		if (r < 8)
			return RUN_W'(len + $urandom_range(0, 3));
		if (r < 9)
			return '1;
		return RUN_W'($urandom);
	endfunction

	// Aim at range edges, the run boundary, gaps and the outskirts of the table.
	function automatic logic [CP_W-1:0] aim_codepoint(input int f);
		int n, k, r;
		int unsigned s, e, x;
		n = live_count(f);
		if (n == 0)
			return CP_W'($urandom_range(0, CP_MAX));
		k = $urandom_range(0, n - 1);
		s = ent_start[f][k];
		e = ent_last[f][k];
		r = $urandom_range(0, 99);
		if (r < 12)
			x = s;
		else if (r < 24)
			x = e;
		else if (r < 36)
			x = s + ent_run[f][k];
		else if (r < 46)
			x = s + ent_run[f][k] + 1;
		else if (r < 62)
			x = $urandom_range(s, e);
		else if (r < 72)
			x = (s > 0) ? s - 1 : 0;
		else if (r < 80)
			x = e + 1;
		else if (r < 85)
			x = $urandom_range(0, ent_start[f][0]);
		else if (r < 90)
			x = $urandom_range(ent_last[f][n-1], CP_MAX);
		else
			x = $urandom_range(0, CP_MAX);
		if (x > CP_MAX)
			x = CP_MAX;
		return CP_W'(x);
	endfunction

	task automatic push_word(input req_word_t w);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= w.opcode;
		req_ch.form        <= w.form;
		req_ch.entry_index <= w.entry_index;
		req_ch.codepoint   <= w.codepoint;
		req_ch.range_last  <= w.range_last;
		req_ch.run_length  <= w.run_length;
		req_ch.check_byte  <= w.check_byte;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_load(input int f, input int idx, input logic [CP_W-1:0] s,
			input logic [CP_W-1:0] e, input logic [RUN_W-1:0] run,
			input logic [CHECK_W-1:0] chk);
		req_word_t w;
		w.opcode      = OP_LOAD;
		w.form        = FORM_W'(f);
		w.entry_index = ENTRY_IDX_W'(idx);
		w.codepoint   = s;
		w.range_last  = e;
		w.run_length  = run;
		w.check_byte  = chk;
		if (f < FORMS) begin
			ent_start[f][idx] = s;
			ent_last[f][idx]  = e;
			ent_run[f][idx]   = run;
		end
		push_word(w);
	endtask

	task automatic send_lookup(input int f, input logic [CP_W-1:0] cp);
		req_word_t w;
		w.opcode      = OP_LOOKUP;
		w.form        = FORM_W'(f);
		w.entry_index = ENTRY_IDX_W'($urandom);
		w.codepoint   = cp;
		w.range_last  = CP_W'($urandom);
		w.run_length  = RUN_W'($urandom);
		w.check_byte  = CHECK_W'($urandom);
		push_word(w);
	endtask

	// Drop valid, wait for the last owed result, then let the pipeline go quiet.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_counts(input bit stray);
		drain();
		for (int f = 0; f < FORMS; f++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(f);
			cfg_wdata <= COUNT_W'(count_plan[f]);
			@(posedge clk);
		end
		// An index past the register list must leave every count alone.
		if (stray) begin
			cfg_index <= CFG_IDX_W'(FORMS + $urandom_range(0, 3));
			cfg_wdata <= COUNT_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Load entries 0..n-1: sorted disjoint ranges, or arbitrary ones when messy.
	task automatic build_table(input int f, input int n, input bit messy, input bit wide);
		int unsigned region, base, span, s, e;
		int r;
		r = $urandom_range(0, 2);
		region = (wide || r == 0) ? 32'h110000 : (r == 1) ? 32'h4000 : n * 8;
		if (region < n * 4)
			region = n * 4;
		base = $urandom_range(0, 32'h110000 - region);
		span = region / n;
		for (int k = 0; k < n; k++) begin
			if (messy) begin
				s = $urandom_range(0, CP_MAX);
				e = $urandom_range(0, 1) ? s + $urandom_range(0, 255) : $urandom_range(0, CP_MAX);
				if (e > CP_MAX)
					e = CP_MAX;
			end else begin
				s = base + k * span + $urandom_range(0, span / 4);
				e = s + $urandom_range(0, span / 2 - 1);
			end
			send_load(f, k, CP_W'(s), CP_W'(e), pick_run(e - s), CHECK_W'($urandom));
		end
	endtask

	task automatic mixed_word();
		int r, f, k;
		logic [CP_W-1:0] s;
		r = $urandom_range(0, 99);
		if (r < 78) begin
			f = $urandom_range(0, FORMS - 1);
			send_lookup(f, aim_codepoint(f));
		end else if (r < 88) begin
			f = $urandom_range(0, FORMS - 1);
			k = (live_count(f) > 0 && $urandom_range(0, 1)) ? $urandom_range(0, live_count(f) - 1)
				: $urandom_range(0, ENTRIES_PER_FORM - 1);
			s = CP_W'($urandom_range(0, CP_MAX));
			send_load(f, k, s, (s > CP_MAX - 1023) ? CP_MAX : s + CP_W'($urandom_range(0, 1023)),
				pick_run($urandom_range(0, 1023)), CHECK_W'($urandom));
		end else if (r < 94) begin
			send_lookup($urandom_range(FORMS, 7), CP_W'($urandom_range(0, CP_MAX)));
		end else begin
			send_load($urandom_range(FORMS, 7), $urandom_range(0, ENTRIES_PER_FORM - 1),
				CP_W'($urandom_range(0, CP_MAX)), CP_W'($urandom_range(0, CP_MAX)),
				RUN_W'($urandom), CHECK_W'($urandom));
		end
	endtask

	task automatic run_phase();
		int r, n;
		steady <= ($urandom_range(0, 4) == 0);
		for (int f = 0; f < FORMS; f++) begin
			r = $urandom_range(0, 99);
			if (r < 18)
				continue;
			if (f == FORM_DECOMPOSED && r < 33) begin
				// Full table from the fill: reuse it, sometimes past saturation.
				n = (r < 23) ? $urandom_range(ENTRIES_PER_FORM + 1, 2047)
					: $urandom_range(61, ENTRIES_PER_FORM);
			end else begin
				r = $urandom_range(0, 99);
				n = (r < 10) ? 0 : (r < 75) ? $urandom_range(1, 12) : $urandom_range(13, 48);
				if (n > 0)
					build_table(f, n, $urandom_range(0, 4) == 0, 1'b0);
			end
			count_plan[f] = n;
		end
		program_counts($urandom_range(0, 5) == 0);
		repeat (PHASE_WORDS) mixed_word();
	endtask

	initial begin
		int mark;
		req_ch.valid       <= 1'b0;
		req_ch.opcode      <= OP_LOAD;
		req_ch.form        <= '0;
		req_ch.entry_index <= '0;
		req_ch.codepoint   <= '0;
		req_ch.range_last  <= '0;
		req_ch.run_length  <= '0;
		req_ch.check_byte  <= '0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_wdata          <= '0;
		steady             <= 1'b0;
		words_sent = 0;
		for (int f = 0; f < FORMS; f++)
			count_plan[f] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty tables, invalid forms, then a pair of hand-made tables.
		send_lookup(FORM_COMPOSED, '0);
		send_lookup(FORM_COMPAT_DECOMPOSED, CP_MAX);
		send_lookup(FORMS, 21'h001234);
		send_lookup(FORMS + 3, CP_MAX);
		send_load(FORMS + 2, 0, 21'h000010, 21'h000020, 24'h000005, 8'h77);
		send_load(FORM_COMPOSED, 0, '0, 21'h00000F, '0, 8'hFF);
		send_load(FORM_COMPOSED, 1, 21'h000100, CP_MAX, 24'hFFFFFF, 8'hA5);
		send_load(FORM_COMPAT_DECOMPOSED, ENTRIES_PER_FORM - 1, CP_MAX, CP_MAX, '0, 8'h01);
		send_load(FORM_COMPAT_COMPOSED, 0, 21'h000040, 21'h000080, 24'h000010, 8'h3C);
		count_plan[FORM_COMPOSED]        = 2;
		count_plan[FORM_COMPAT_COMPOSED] = 1;
		program_counts(1'b1);
		send_lookup(FORM_COMPOSED, '0);
		send_lookup(FORM_COMPOSED, 21'h000005);
		send_lookup(FORM_COMPOSED, 21'h000050);
		send_lookup(FORM_COMPOSED, CP_MAX);
		send_lookup(FORM_COMPOSED, 21'h000100);
		send_lookup(FORM_COMPAT_COMPOSED, 21'h00003F);
		send_lookup(FORM_COMPAT_COMPOSED, 21'h000050);
		send_lookup(FORM_COMPAT_COMPOSED, 21'h000051);
		send_lookup(FORM_COMPAT_COMPOSED, 21'h000081);
		send_lookup(FORM_DECOMPOSED, '0);
		send_load(FORM_COMPOSED, 1, 21'h000100, CP_MAX, 24'hFFFFFF, 8'h00);
		send_lookup(FORM_COMPOSED, 21'h008000);

		// Fill one table completely, then count past the end and exactly to it.
		build_table(FORM_DECOMPOSED, ENTRIES_PER_FORM, 1'b0, 1'b1);
		count_plan[FORM_DECOMPOSED] = 2047;
		program_counts(1'b0);
		repeat (PHASE_WORDS) mixed_word();
		count_plan[FORM_DECOMPOSED] = ENTRIES_PER_FORM;
		program_counts(1'b0);
		repeat (40) mixed_word();

		mark = words_sent;
		while (words_sent < mark + RANDOM_WORDS)
			run_phase();
		drain();

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
